// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, muted during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/dngo_pkg.sv -----
// Package: types, constants and glyph bitmaps of the number overlay.
package dngo_pkg;

   localparam int VALUE_W = 16;
   localparam int COORD_W = 12;
   localparam int CODE_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SHOWN_VALUE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_ROW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_COL  = 2'd2;

   localparam int GLYPH_COLS = 6;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_CODES = 10;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [VALUE_W-1:0] DIV10_RECIP = 16'hCCCD;
   localparam int DIV10_SHIFT = 19;
   localparam logic [CODE_W-1:0] MAX_CODE = 4'd9;

   typedef logic [GLYPH_COLS-1:0] glyph_row_type;
   typedef glyph_row_type glyph_type [0:GLYPH_ROWS-1];

   // leftmost glyph column in bit 5
   localparam glyph_type GLYPHS [0:GLYPH_CODES-1] = '{
      '{6'h1C, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h1C},
      '{6'h08, 6'h18, 6'h08, 6'h08, 6'h08, 6'h08, 6'h3E},
      '{6'h1C, 6'h22, 6'h02, 6'h04, 6'h08, 6'h10, 6'h3E},
      '{6'h1C, 6'h22, 6'h02, 6'h0C, 6'h02, 6'h22, 6'h1C},
      '{6'h04, 6'h0C, 6'h14, 6'h24, 6'h3E, 6'h04, 6'h04},
      '{6'h3E, 6'h20, 6'h3C, 6'h02, 6'h02, 6'h22, 6'h1C},
      '{6'h1C, 6'h22, 6'h20, 6'h3C, 6'h22, 6'h22, 6'h1C},
      '{6'h3E, 6'h02, 6'h04, 6'h08, 6'h08, 6'h08, 6'h08},
      '{6'h1C, 6'h22, 6'h22, 6'h1C, 6'h22, 6'h22, 6'h1C},
      '{6'h1C, 6'h22, 6'h22, 6'h1E, 6'h02, 6'h22, 6'h1C}
   };

endpackage

// ----- rtl/core/dngo_ifs.sv -----
// Valid/ready channel interfaces for pixel requests and overlay responses.
interface dngo_req_if;
   logic                         valid;
   logic                         ready;
   logic [dngo_pkg::COORD_W-1:0] pixel_row;
   logic [dngo_pkg::COORD_W-1:0] pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface dngo_rsp_if;
   logic valid;
   logic ready;
   logic covered;
   logic lit;

   modport source (output valid, output covered, output lit, input ready);
   modport sink   (input valid, input covered, input lit, output ready);
endinterface

// ----- rtl/core/decimal_number_glyph_overlay_unit.sv -----
// Top level: decimal number glyph overlay on a streamed pixel raster.
// One pixel beat is accepted per clock unless back-pressure or a digit pass
// (req_bus.ready low) holds it; it then goes through the input register and
// the result register. A nonzero shown_value write starts digit extraction,
// one decimal digit per clock via a divide-by-ten multiplier unless a CSR
// write holds it, up to MAX_DIGITS digits. Anchor writes apply at once.
`include "assert_macros.svh"

module decimal_number_glyph_overlay_unit #(
   parameter int MAX_DIGITS  = 5,
   parameter int IMAGE_DIM   = 4096,
   parameter int CELL_WIDTH  = 5,
   parameter int CELL_HEIGHT = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   dngo_req_if.sink                       req_bus,
   dngo_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [dngo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dngo_pkg::VALUE_W-1:0]   csr_wdata
);
   import dngo_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DIGIT_SPAN = GLYPH_COLS * CELL_WIDTH;
   localparam int GLYPH_SPAN = GLYPH_ROWS * CELL_HEIGHT;
   localparam int DIM_W = 17;
   localparam logic [DIM_W-1:0] IMAGE_LIM = DIM_W'(IMAGE_DIM);
   localparam int DW = COORD_W + 1;

   // configuration and digit state
   logic [COORD_W-1:0] anchor_row_ff, anchor_col_ff;
   logic [CODE_W-1:0]  digits_ff [0:MAX_DIGITS-1];
   logic [CNT_W-1:0]   count_ff;
   logic               busy_ff;
   logic               neg_ff;
   logic [VALUE_W-1:0] mag_ff;

   logic [VALUE_W-1:0]   wr_mag;
   logic [2*VALUE_W-1:0] div_prod;
   logic [VALUE_W-1:0]   div_q;
   logic [VALUE_W-1:0]   div_r;

   assign wr_mag   = csr_wdata[VALUE_W-1] ? (~csr_wdata + 1'b1) : csr_wdata;
   assign div_prod = mag_ff * DIV10_RECIP;
   assign div_q    = VALUE_W'(div_prod >> DIV10_SHIFT);
   assign div_r    = mag_ff - ((div_q << 3) + (div_q << 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_row_ff <= '0;
         anchor_col_ff <= '0;
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHOWN_VALUE: begin
               neg_ff   <= csr_wdata[VALUE_W-1];
               mag_ff   <= wr_mag;
               count_ff <= '0;
               busy_ff  <= (wr_mag != '0);
               for (int i = 0; i < MAX_DIGITS; i++) begin
                  digits_ff[i] <= '0;
               end
            end
            CSR_ANCHOR_ROW: anchor_row_ff <= csr_wdata[COORD_W-1:0];
            CSR_ANCHOR_COL: anchor_col_ff <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end else if (busy_ff) begin
         digits_ff[count_ff[IDX_W-1:0]] <= neg_ff ? '0 : div_r[CODE_W-1:0];
         count_ff <= count_ff + 1'b1;
         mag_ff   <= div_q;
         busy_ff  <= (div_q != '0) && (count_ff != CNT_W'(MAX_DIGITS - 1));
      end
   end

   // pixel pipeline: input register, then result register
   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_row_ff, s1_col_ff;
   logic               rsp_valid_ff, covered_ff, lit_ff;
   logic               rsp_free, s1_free;

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_free       = !s1_valid_ff || rsp_free;
   assign req_bus.ready = s1_free && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_bus.valid && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_row_ff <= req_bus.pixel_row;
         s1_col_ff <= req_bus.pixel_col;
      end
   end

   logic signed [DW-1:0] dr, dc;
   logic [DW-1:0]        dc_lim;
   logic [COORD_W-1:0]   drm1, dcm1, col_off;
   logic [IDX_W-1:0]     k;
   logic [2:0]           m, n;
   logic [CODE_W-1:0]    code;
   logic [2:0]           grow;
   logic                 in_image, covered_in, lit_in;

   always_comb begin
      dr     = $signed({1'b0, anchor_row_ff}) - $signed({1'b0, s1_row_ff});
      dc     = $signed({1'b0, anchor_col_ff}) - $signed({1'b0, s1_col_ff});
      dc_lim = DW'(count_ff) * DW'(DIGIT_SPAN);
      drm1   = dr[COORD_W-1:0] - 1'b1;
      dcm1   = dc[COORD_W-1:0] - 1'b1;
      in_image = ({{(DIM_W-COORD_W){1'b0}}, s1_row_ff} < IMAGE_LIM)
              && ({{(DIM_W-COORD_W){1'b0}}, s1_col_ff} < IMAGE_LIM);
      covered_in = in_image
                && !dr[DW-1] && (dr != '0) && (dr <= DW'(GLYPH_SPAN))
                && !dc[DW-1] && (dc != '0) && ({1'b0, dc[COORD_W-1:0]} <= dc_lim);

      k = '0;
      for (int j = 1; j < MAX_DIGITS; j++) begin
         if (dcm1 >= COORD_W'(j * DIGIT_SPAN)) k = IDX_W'(j);
      end
      col_off = dcm1 - COORD_W'(COORD_W'(k) * COORD_W'(DIGIT_SPAN));
      m = '0;
      for (int j = 1; j < GLYPH_COLS; j++) begin
         if (col_off >= COORD_W'(j * CELL_WIDTH)) m = 3'(j);
      end
      n = '0;
      for (int j = 1; j < GLYPH_ROWS; j++) begin
         if (drm1 >= COORD_W'(j * CELL_HEIGHT)) n = 3'(j);
      end
      grow = 3'(GLYPH_ROWS - 1) - n;
      code = digits_ff[k];
      if (code > MAX_CODE) code = '0;
      lit_in = covered_in && GLYPHS[code][grow][m];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && s1_valid_ff) begin
         covered_ff <= covered_in;
         lit_ff     <= lit_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.covered = covered_ff;
   assign rsp_bus.lit     = lit_ff;

   logic zero_wr;
   assign zero_wr = csr_we && (csr_index == CSR_SHOWN_VALUE) && (csr_wdata == '0);

   `ASSERT_ALWAYS(a_no_accept_while_busy, clock, busy_ff |-> !req_bus.ready, "ready while busy")
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_DIGITS), "count overflow")
   `ASSERT_CLK(a_lit_needs_cover, clock, reset, rsp_valid_ff && lit_ff |-> covered_ff, "lit uncovered")
   `ASSERT_CLK(a_zero_value_empty, clock, reset, zero_wr |=> count_ff == '0 && !busy_ff, "digits left")

endmodule
